// ----- rtl/text_console_cursor_top_macros.svh -----
// ----------------------------------------------------------------------------
// Text console cursor assertion macros
// Shared concurrent assertion forms for the cursor controller.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_TOP_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CCUR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define CCUR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ccur_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console cursor package
// Shared widths, character codes, command types and defaults.
// ----------------------------------------------------------------------------
package ccur_pkg;

  localparam int CCUR_COLUMNS     = 60;
  localparam int CCUR_ROWS        = 20;
  localparam int CCUR_TAB_CELLS   = 4;
  localparam int CCUR_QUEUE_DEPTH = 2;

  localparam int MAX_RESULTS = 4;
  localparam int NRES_W      = $clog2(MAX_RESULTS);

  localparam int CHAR_W     = 8;
  localparam int CPOS_W     = 8;
  localparam int RPOS_W     = 8;
  localparam int DRAW_COL_W = 6;
  localparam int DRAW_ROW_W = 5;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_PRINT = 2'd0,
    KIND_TAB   = 2'd1,
    KIND_LF    = 2'd2,
    KIND_CR    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] glyph;
    logic              adv;
  } cmd_t;

endpackage

// ----- rtl/text_console_cursor_top.sv -----
// ----------------------------------------------------------------------------
// Text console cursor controller
// Tracks the cursor of a character grid and emits glyph draws and scrolls.
// ----------------------------------------------------------------------------
// Each character transaction produces results from the back-end sequencer, one
// per cycle while the output is not stalled: one result for a printable byte,
// line feed or carriage return, and one result per filled cell for a tab, up
// to TAB_CELLS and at most four. A short command queue lets new characters
// be taken while earlier ones are still being expanded, and an output
// register holds each result until it is taken. Set display_attached through
// cfg_we and cfg_wdata only while no transaction is in flight.
module text_console_cursor_top import ccur_pkg::*; #(
  parameter int COLUMNS     = CCUR_COLUMNS,
  parameter int ROWS        = CCUR_ROWS,
  parameter int TAB_CELLS   = CCUR_TAB_CELLS,
  parameter int QUEUE_DEPTH = CCUR_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CHAR_W-1:0]     char_code,
  input  logic                  advance,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  draw,
  output logic [DRAW_COL_W-1:0] draw_col,
  output logic [DRAW_ROW_W-1:0] draw_row,
  output logic [CHAR_W-1:0]     glyph,
  output logic                  scroll,
  output logic [DRAW_COL_W-1:0] cursor_col,
  output logic [DRAW_ROW_W-1:0] cursor_row,
  output logic                  last
);

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  ccur_front u_front (
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .advance   (advance),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  ccur_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  ccur_back #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_CELLS (TAB_CELLS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .draw       (draw),
    .draw_col   (draw_col),
    .draw_row   (draw_row),
    .glyph      (glyph),
    .scroll     (scroll),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .last       (last)
  );

endmodule

// ----- rtl/ccur_front.sv -----
// ----------------------------------------------------------------------------
// Text console cursor front end
// Accepts character transactions and classifies them into queue commands.
// ----------------------------------------------------------------------------
module ccur_front import ccur_pkg::*; (
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              advance,
  input  logic              q_full,
  output logic              push,
  output cmd_t              push_cmd
);

  kind_t kind;

  always_comb begin
    case (char_code)
      CH_TAB:  kind = KIND_TAB;
      CH_LF:   kind = KIND_LF;
      CH_CR:   kind = KIND_CR;
      default: kind = KIND_PRINT;
    endcase
  end

  assign in_ready = !q_full && !rst;
  assign push     = in_valid && in_ready;

  assign push_cmd.kind  = kind;
  assign push_cmd.glyph = char_code;
  assign push_cmd.adv   = advance;

endmodule

// ----- rtl/ccur_queue.sv -----
// ----------------------------------------------------------------------------
// Text console cursor command queue
// Short register queue between the front end and the result sequencer.
// ----------------------------------------------------------------------------
module ccur_queue import ccur_pkg::*; #(
  parameter int DEPTH = CCUR_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/ccur_back.sv -----
// ----------------------------------------------------------------------------
// Text console cursor back end
// Steps the cursor and emits one result per cycle, such as a draw or a cursor move, while the output is not stalled.
// ----------------------------------------------------------------------------
module ccur_back import ccur_pkg::*; #(
  parameter int COLUMNS   = CCUR_COLUMNS,
  parameter int ROWS      = CCUR_ROWS,
  parameter int TAB_CELLS = CCUR_TAB_CELLS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  head_valid,
  input  cmd_t                  head_cmd,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  draw,
  output logic [DRAW_COL_W-1:0] draw_col,
  output logic [DRAW_ROW_W-1:0] draw_row,
  output logic [CHAR_W-1:0]     glyph,
  output logic                  scroll,
  output logic [DRAW_COL_W-1:0] cursor_col,
  output logic [DRAW_ROW_W-1:0] cursor_row,
  output logic                  last
);

`include "text_console_cursor_top_macros.svh"

  localparam int PHASE_W = $clog2(TAB_CELLS);

  logic               display_attached;
  logic [CPOS_W-1:0]  col_pos;
  logic [RPOS_W-1:0]  row_pos;
  logic [PHASE_W-1:0] phase;
  logic [NRES_W-1:0]  res_cnt;

  logic [CPOS_W-1:0]  col_pos_next;
  logic [RPOS_W-1:0]  row_pos_next;
  logic [PHASE_W-1:0] phase_next;

  logic               load;
  logic               res_draw;
  logic               res_scroll;
  logic               res_last;
  logic [CHAR_W-1:0]  res_glyph;

  logic [CPOS_W-1:0]  col_inc;
  logic               wrap;
  logic               row_at_end;
  logic [RPOS_W-1:0]  nl_row;
  logic [CPOS_W-1:0]  step_col;
  logic [RPOS_W-1:0]  step_row;
  logic [PHASE_W-1:0] step_phase;
  logic               step_scroll;

  always_comb begin
    col_inc     = col_pos + CPOS_W'(1);
    wrap        = (col_inc >= CPOS_W'(COLUMNS));
    row_at_end  = !((row_pos + RPOS_W'(1)) < RPOS_W'(ROWS));
    nl_row      = row_at_end ? row_pos : row_pos + RPOS_W'(1);
    step_col    = wrap ? '0 : col_inc;
    step_row    = wrap ? nl_row : row_pos;
    step_scroll = wrap && row_at_end;
    if (wrap || (phase == PHASE_W'(TAB_CELLS - 1))) begin
      step_phase = '0;
    end else begin
      step_phase = phase + PHASE_W'(1);
    end
  end

  always_comb begin
    col_pos_next = col_pos;
    row_pos_next = row_pos;
    phase_next   = phase;
    res_draw     = 1'b0;
    res_scroll   = 1'b0;
    res_last     = 1'b1;
    res_glyph    = '0;
    case (head_cmd.kind)
      KIND_TAB: begin
        col_pos_next = step_col;
        row_pos_next = step_row;
        phase_next   = step_phase;
        res_draw     = 1'b1;
        res_scroll   = step_scroll;
        res_glyph    = CH_SPACE;
        res_last     = (step_phase == '0) || (res_cnt == NRES_W'(MAX_RESULTS - 1));
      end
      KIND_LF: begin
        col_pos_next = '0;
        row_pos_next = nl_row;
        phase_next   = '0;
        res_scroll   = row_at_end;
      end
      KIND_CR: begin
        res_last = 1'b1;
      end
      default: begin
        res_draw  = 1'b1;
        res_glyph = head_cmd.glyph;
        if (head_cmd.adv) begin
          col_pos_next = step_col;
          row_pos_next = step_row;
          phase_next   = step_phase;
          res_scroll   = step_scroll;
        end
      end
    endcase
  end

  assign load = head_valid && (!out_valid || out_ready);
  assign pop  = load && res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_attached <= 1'b1;
      col_pos          <= '0;
      row_pos          <= '0;
      phase            <= '0;
      res_cnt          <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        display_attached <= cfg_wdata;
      end
      if (load) begin
        col_pos   <= col_pos_next;
        row_pos   <= row_pos_next;
        phase     <= phase_next;
        res_cnt   <= res_last ? '0 : res_cnt + NRES_W'(1);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      draw       <= res_draw && display_attached;
      draw_col   <= (res_draw && display_attached) ? col_pos[DRAW_COL_W-1:0] : '0;
      draw_row   <= (res_draw && display_attached) ? row_pos[DRAW_ROW_W-1:0] : '0;
      glyph      <= (res_draw && display_attached) ? res_glyph : '0;
      scroll     <= res_scroll && display_attached;
      cursor_col <= col_pos_next[DRAW_COL_W-1:0];
      cursor_row <= row_pos_next[DRAW_ROW_W-1:0];
      last       <= res_last;
    end
  end

  `CCUR_ASSERT(a_col_in_grid, col_pos < CPOS_W'(COLUMNS), "cursor column outside grid")
  `CCUR_ASSERT(a_row_in_grid, row_pos < RPOS_W'(ROWS), "cursor row outside grid")
  `CCUR_ASSERT(a_phase_zero, (col_pos != '0) || (phase == '0), "phase set at column zero")
  `CCUR_ASSERT_NEXT(a_pop_marks_last, pop, out_valid && last, "pop without final result")

endmodule
